/* hw/rtl/mpbd_pkg.sv */
// Shared types and constants for the mipmap pyramid box downsampler.
`default_nettype none

package mpbd_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxLevels = 10;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned SumW    = ChanW + 1;
  localparam int unsigned CfgDatW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned PosW    = 9;
  localparam int unsigned DimRstVal = 1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [SumW-1:0] r;
    logic [SumW-1:0] g;
    logic [SumW-1:0] b;
  } sum_t;

  typedef struct packed {
    logic valid;
    rgb_t pix;
  } token_t;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    rgb_t            pix;
    logic            last;
  } cell_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mpbd_px_if.sv */
// Base pixel channel: valid/ready with one RGB pixel.
`default_nettype none

interface mpbd_px_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mpbd_res_if.sv */
// Result channel: valid/ready with one downsampled pixel and its position.
`default_nettype none

interface mpbd_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic [8:0] col;
  logic [8:0] row;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last;

  modport source (output valid, level, col, row, out_red, out_green, out_blue, last,
                  input ready);
  modport sink (input valid, level, col, row, out_red, out_green, out_blue, last,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/mpbd_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
`default_nettype none

interface mpbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mpbd_cell.sv */
// One pyramid level: position counters, pending pixel, pair-sum line and 2x2 average.
`default_nettype none

module mpbd_cell import mpbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned LVL       = 0,
  parameter int unsigned DW        = $clog2(MAX_WIDTH) + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          restart_i,
  input  wire logic [DW-1:0] w_i,
  input  wire logic [DW-1:0] h_i,
  input  wire token_t        tk_i,
  input  wire logic          next_prod_i,
  output logic               prod_o,
  output logic               done_o,
  output token_t             tk_o,
  output cell_res_t          res_o
);

  localparam int unsigned Depth = ((MAX_WIDTH >> (LVL + 1)) > 0) ?
                                  (MAX_WIDTH >> (LVL + 1)) : 1;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DW-1:0]    col_q, col_d, row_q, row_d;
  rgb_t             pend_q;
  sum_t             line_mem [Depth];
  sum_t             rd_q;
  sum_t             sums;
  sum_t             b_sum_q;
  logic             b_valid_q;
  logic [PosW-1:0]  b_col_q, b_row_q;
  logic             b_last_q;
  logic [DW-1:0]    c, r, c_half;
  logic [DW+PosW-1:0] cx, rx;
  logic [AW-1:0]    addr;
  logic             lvl_on, in_c, in_r, take, wr_en, rd_en;
  logic [SumW:0]    avg_r, avg_g, avg_b;

  always_comb begin
    lvl_on = (w_i != '0) && (h_i != '0);
    c      = (col_q >= w_i) ? '0 : col_q;
    r      = (row_q >= h_i) ? '0 : row_q;
    in_c   = c < {w_i[DW-1:1], 1'b0};
    in_r   = r < {h_i[DW-1:1], 1'b0};
    prod_o = lvl_on && c[0] && in_c && r[0] && in_r;
    take   = tk_i.valid && en_i && lvl_on;
    done_o = tk_i.valid && !prod_o;
    wr_en  = take && c[0] && in_c && !r[0];
    rd_en  = take && prod_o;
    c_half = c >> 1;
    addr   = c_half[AW-1:0];
    cx     = {{PosW{1'b0}}, c};
    rx     = {{PosW{1'b0}}, r};
    sums.r = {1'b0, tk_i.pix.r} + {1'b0, pend_q.r};
    sums.g = {1'b0, tk_i.pix.g} + {1'b0, pend_q.g};
    sums.b = {1'b0, tk_i.pix.b} + {1'b0, pend_q.b};
    if (c == w_i - 1'b1) begin
      col_d = '0;
      row_d = (r == h_i - 1'b1) ? '0 : r + 1'b1;
    end else begin
      col_d = c + 1'b1;
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pend_q    <= '0;
      b_valid_q <= 1'b0;
    end else if (restart_i) begin
      col_q     <= '0;
      row_q     <= '0;
      pend_q    <= '0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= rd_en;
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
        if (!c[0]) begin
          pend_q <= tk_i.pix;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      b_sum_q  <= sums;
      b_col_q  <= cx[PosW:1];
      b_row_q  <= rx[PosW:1];
      b_last_q <= !next_prod_i;
    end
  end

  // line store, one port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[addr] <= sums;
    end
    if (rd_en) begin
      rd_q <= line_mem[addr];
    end
  end

  always_comb begin
    avg_r = {1'b0, b_sum_q.r} + {1'b0, rd_q.r};
    avg_g = {1'b0, b_sum_q.g} + {1'b0, rd_q.g};
    avg_b = {1'b0, b_sum_q.b} + {1'b0, rd_q.b};
    tk_o.valid  = b_valid_q;
    tk_o.pix.r  = avg_r[SumW:2];
    tk_o.pix.g  = avg_g[SumW:2];
    tk_o.pix.b  = avg_b[SumW:2];
    res_o.valid = b_valid_q;
    res_o.col   = b_col_q;
    res_o.row   = b_row_q;
    res_o.pix   = tk_o.pix;
    res_o.last  = b_last_q;
  end

endmodule

`default_nettype wire

/* hw/rtl/mipmap_pyramid_box_downsampler_unit.sv */
// Top level of the streaming 2x2 box-filter mipmap pyramid builder.
// Base RGB pixels enter in raster order; every completed 2x2 block on any level
// comes out with its level, column and row, lowest level first, last set on the
// final result of each input pixel. One pixel is in flight at a time: it walks the
// chain of level cells, up to the first level that completes no block (counter
// update and line store read at the edge that takes it, average ready for the next
// level in the following cycle), so the next pixel is taken only after the walk
// ends, and stalls on the result side hold the chain. A finished result waits in
// the output register while the next pixel is taken. Writing src_width or
// src_height restarts the frame; sizes of zero act as one and sizes above
// MAX_WIDTH act as MAX_WIDTH. No clearing pass after reset.
`default_nettype none

module mipmap_pyramid_box_downsampler_unit import mpbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_LEVELS = DefMaxLevels
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mpbd_px_if.sink    px_i,
  mpbd_res_if.source res_o,
  mpbd_cfg_if.sink   cfg_i
);

  localparam int unsigned DW     = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned DimRst = (MAX_WIDTH < DimRstVal) ? MAX_WIDTH : DimRstVal;

  logic [DW-1:0]       wbase_q, hbase_q, cfg_dim;
  logic                restart, in_acc, busy_q, en, out_load;
  logic                tk_vld_q;
  rgb_t                tk_pix_q;
  token_t              tk [MAX_LEVELS+1];
  logic [MAX_LEVELS:0] prod;
  logic [MAX_LEVELS-1:0] done, res_valid;
  cell_res_t           res [MAX_LEVELS];
  cell_res_t           res_sel;
  logic [LevelW-1:0]   level_sel;
  logic                done_any;

  logic                out_valid_q;
  logic [LevelW-1:0]   out_level_q;
  cell_res_t           out_q;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign restart = cfg_i.valid && ((cfg_i.index == CFG_SRC_WIDTH) ||
                                   (cfg_i.index == CFG_SRC_HEIGHT));

  always_comb begin
    if (cfg_i.data == '0) begin
      cfg_dim = DW'(1);
    end else if (32'(cfg_i.data) > MAX_WIDTH) begin
      cfg_dim = DW'(MAX_WIDTH);
    end else begin
      cfg_dim = DW'(cfg_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbase_q <= DW'(DimRst);
      hbase_q <= DW'(DimRst);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SRC_WIDTH:  wbase_q <= cfg_dim;
        CFG_SRC_HEIGHT: hbase_q <= cfg_dim;
        default: ;
      endcase
    end
  end

  // input side
  assign en       = !(out_valid_q && !res_o.ready);
  assign px_i.ready = !busy_q;
  assign in_acc   = px_i.valid && !busy_q;
  assign done_any = (|done) || tk[MAX_LEVELS].valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      tk_vld_q <= 1'b0;
    end else if (in_acc) begin
      busy_q   <= 1'b1;
      tk_vld_q <= 1'b1;
    end else if (en) begin
      tk_vld_q <= 1'b0;
      if (done_any) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tk_pix_q <= '{r: px_i.in_red, g: px_i.in_green, b: px_i.in_blue};
    end
  end

  // chain of level cells
  assign tk[0] = '{valid: tk_vld_q, pix: tk_pix_q};
  assign prod[MAX_LEVELS] = 1'b0;

  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_cell
    mpbd_cell #(
      .MAX_WIDTH (MAX_WIDTH),
      .LVL       (l),
      .DW        (DW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .restart_i   (restart),
      .w_i         (wbase_q >> l),
      .h_i         (hbase_q >> l),
      .tk_i        (tk[l]),
      .next_prod_i (prod[l+1]),
      .prod_o      (prod[l]),
      .done_o      (done[l]),
      .tk_o        (tk[l+1]),
      .res_o       (res[l])
    );
    assign res_valid[l] = res[l].valid;
  end

  always_comb begin
    res_sel   = '0;
    level_sel = '0;
    for (int unsigned l = 0; l < MAX_LEVELS; l++) begin
      if (res[l].valid) begin
        res_sel   = res[l];
        level_sel = LevelW'(l + 1);
      end
    end
  end

  // output register
  assign out_load = en && (|res_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q       <= res_sel;
      out_level_q <= level_sel;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.level     = out_level_q;
  assign res_o.col       = out_q.col;
  assign res_o.row       = out_q.row;
  assign res_o.out_red   = out_q.pix.r;
  assign res_o.out_green = out_q.pix.g;
  assign res_o.out_blue  = out_q.pix.b;
  assign res_o.last      = out_q.last;

  // checks
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(res_valid))
    else $error("more than one level holds a result");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!(|res_valid) && !tk_vld_q))
    else $error("work in the chain while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (busy_q && tk_vld_q))
    else $error("accepted pixel not entered into the chain");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && busy_q) |=> $stable(res_valid))
    else $error("chain moved during output stall");

endmodule

`default_nettype wire
